// File: rtl/core/lch_pkg.sv
// ----------------------------------------------------------------------------
// lch_pkg
// Shared constants and operation codes of the lattice contact heuristic.
// ----------------------------------------------------------------------------
package lch_pkg;

   // Default geometry of the bead store and of a lattice coordinate.
   localparam int MAX_BEADS  = 256;
   localparam int COORD_BITS = 10;

   // Fixed widths of the request and response fields.
   localparam int OP_W      = 2;
   localparam int CNT_OUT_W = 9;
   localparam int OUT_MAX   = 511;

   // Request operation codes; the fourth code is ignored.
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

endpackage

// File: rtl/core/lch_if.sv
// ----------------------------------------------------------------------------
// lch_req_if / lch_rsp_if
// Valid/ready channels carrying lattice requests and heuristic responses.
// ----------------------------------------------------------------------------
interface lch_req_if #(
   parameter int COORD_BITS = lch_pkg::COORD_BITS
);
   logic                          valid;
   logic                          ready;
   logic [lch_pkg::OP_W-1:0]      operation;
   logic signed [COORD_BITS-1:0]  pos_x;
   logic signed [COORD_BITS-1:0]  pos_y;
   logic signed [COORD_BITS-1:0]  pos_z;
   logic                          is_h;

   modport source (output valid, operation, pos_x, pos_y, pos_z, is_h, input ready);
   modport sink   (input valid, operation, pos_x, pos_y, pos_z, is_h, output ready);
endinterface

interface lch_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lch_pkg::CNT_OUT_W-1:0] collisions;
   logic [lch_pkg::CNT_OUT_W-1:0] contacts;
   logic [lch_pkg::CNT_OUT_W-1:0] heuristic;
   logic                          overflow;

   modport source (output valid, collisions, contacts, heuristic, overflow, input ready);
   modport sink   (input valid, collisions, contacts, heuristic, overflow, output ready);
endinterface

// File: rtl/core/lch_ram.sv
// ----------------------------------------------------------------------------
// lch_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lch_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/lattice_contact_heuristic.sv
// ----------------------------------------------------------------------------
// lattice_contact_heuristic
// Bead store on a 3D cubic lattice with a collision/contact heuristic query.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one request per valid/ready handshake: clear, append a
//   bead, or query a candidate position. Clear and append take effect at the
//   accepting edge and produce no response; an append to a full store is
//   dropped and sets a sticky overflow flag. Operation code 3 is ignored.
//   A query produces exactly one response on rsp_chan: collisions, contacts,
//   heuristic and the overflow flag.
//   Throughput: a clear or append can be accepted right behind another. A
//   query walks the store through the single read port of the bead RAM,
//   one bead per cycle; req_chan is not ready from the acceptance of a
//   query until its response is loaded into the output register.
//   The response sits in an output register. New clear/append requests are
//   accepted while it waits; a query that finishes while the previous
//   response is still stalled holds until the receiver takes it.
//   Reset (synchronous, active high) empties the store and clears the
//   overflow flag; the RAM contents are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module lattice_contact_heuristic #(
   parameter int MAX_BEADS  = lch_pkg::MAX_BEADS,
   parameter int COORD_BITS = lch_pkg::COORD_BITS
) (
   input  logic      clock,
   input  logic      reset,
   lch_req_if.sink   req_chan,
   lch_rsp_if.source rsp_chan
);

   localparam int IDX_W   = $clog2(MAX_BEADS);
   localparam int CNT_W   = $clog2(MAX_BEADS + 1);
   localparam int DIST_W  = COORD_BITS + 3;
   localparam int ENTRY_W = 3 * COORD_BITS + 1;
   localparam int OUT_W   = lch_pkg::CNT_OUT_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   // Clamp a count to the response field.
   function automatic logic [OUT_W-1:0] sat_count(input logic [31:0] v);
      logic [OUT_W-1:0] r;
      if (v > 32'(lch_pkg::OUT_MAX)) begin
         r = OUT_W'(lch_pkg::OUT_MAX);
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

   // Control state
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             dropped_ff, dropped_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [CNT_W-1:0] coll_ff, coll_in;
   logic [CNT_W-1:0] cont_ff, cont_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic signed [COORD_BITS-1:0] cand_x_ff, cand_y_ff, cand_z_ff;
   logic                         cand_h_ff;
   logic [OUT_W-1:0]             rsp_coll_ff, rsp_cont_ff, rsp_heur_ff;
   logic                         rsp_ovf_ff;

   logic req_fire;
   logic load_rsp;

   // Bead RAM ports
   logic               ram_we;
   logic               ram_re;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [ENTRY_W-1:0] ram_rdata;

   // Distance evaluation of the bead read last cycle
   logic signed [COORD_BITS-1:0] mem_x, mem_y, mem_z;
   logic                         mem_h;
   logic signed [COORD_BITS:0]   diff_x, diff_y, diff_z;
   logic [COORD_BITS:0]          abs_x, abs_y, abs_z;
   logic [DIST_W-1:0]            l1_dist;
   logic                         hit_coll, hit_cont;
   logic [CNT_W:0]               heur_wide;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   // Append writes the next free slot; the store is packed {h, z, y, x}.
   assign ram_we    = req_fire && (req_chan.operation == lch_pkg::OP_APPEND)
                      && (count_ff < CNT_W'(MAX_BEADS));
   assign ram_wdata = {req_chan.is_h, req_chan.pos_z, req_chan.pos_y, req_chan.pos_x};
   assign ram_re    = (state_ff == S_SCAN) && (issue_ff < count_ff);

   lch_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_BEADS)
   ) u_bead_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   // L1 distance between the candidate and the stored bead
   always_comb begin
      mem_x  = ram_rdata[COORD_BITS-1:0];
      mem_y  = ram_rdata[2*COORD_BITS-1:COORD_BITS];
      mem_z  = ram_rdata[3*COORD_BITS-1:2*COORD_BITS];
      mem_h  = ram_rdata[ENTRY_W-1];
      diff_x = (COORD_BITS+1)'(cand_x_ff) - (COORD_BITS+1)'(mem_x);
      diff_y = (COORD_BITS+1)'(cand_y_ff) - (COORD_BITS+1)'(mem_y);
      diff_z = (COORD_BITS+1)'(cand_z_ff) - (COORD_BITS+1)'(mem_z);
      abs_x  = diff_x[COORD_BITS] ? (COORD_BITS+1)'(-diff_x) : diff_x;
      abs_y  = diff_y[COORD_BITS] ? (COORD_BITS+1)'(-diff_y) : diff_y;
      abs_z  = diff_z[COORD_BITS] ? (COORD_BITS+1)'(-diff_z) : diff_z;
      l1_dist  = DIST_W'(abs_x) + DIST_W'(abs_y) + DIST_W'(abs_z);
      hit_coll = rd_vld_ff && (l1_dist == '0);
      hit_cont = rd_vld_ff && (l1_dist == DIST_W'(1)) && mem_h;
   end

   // Heuristic: zero on collision, else one plus contacts for an H bead, one for a P bead.
   always_comb begin
      if (coll_ff != '0) begin
         heur_wide = '0;
      end else if (cand_h_ff) begin
         heur_wide = (CNT_W+1)'(cont_ff) + (CNT_W+1)'(1);
      end else begin
         heur_wide = (CNT_W+1)'(1);
      end
   end

   // Next-state logic
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      issue_in     = issue_ff;
      rd_vld_in    = 1'b0;
      coll_in      = coll_ff;
      cont_in      = cont_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      load_rsp     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_chan.operation)
                  lch_pkg::OP_CLEAR: begin
                     count_in   = '0;
                     dropped_in = 1'b0;
                  end
                  lch_pkg::OP_APPEND: begin
                     if (count_ff < CNT_W'(MAX_BEADS)) begin
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  lch_pkg::OP_QUERY: begin
                     state_in = S_SCAN;
                     issue_in = '0;
                     coll_in  = '0;
                     cont_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            // Issue one read a cycle; accumulate the bead read last cycle.
            if (ram_re) begin
               issue_in = issue_ff + CNT_W'(1);
            end
            rd_vld_in = ram_re;
            if (hit_coll) begin
               coll_in = coll_ff + CNT_W'(1);
            end
            if (hit_cont) begin
               cont_in = cont_ff + CNT_W'(1);
            end
            if (!ram_re && !rd_vld_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Hold until the response register is free.
            if (!rsp_valid_in) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         issue_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         coll_ff      <= '0;
         cont_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         issue_ff     <= issue_in;
         rd_vld_ff    <= rd_vld_in;
         coll_ff      <= coll_in;
         cont_ff      <= cont_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire) begin
         cand_x_ff <= req_chan.pos_x;
         cand_y_ff <= req_chan.pos_y;
         cand_z_ff <= req_chan.pos_z;
         cand_h_ff <= req_chan.is_h;
      end
      if (load_rsp) begin
         rsp_coll_ff <= sat_count(32'(coll_ff));
         rsp_cont_ff <= sat_count(32'(cont_ff));
         rsp_heur_ff <= sat_count(32'(heur_wide));
         rsp_ovf_ff  <= dropped_ff;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.collisions = rsp_coll_ff;
   assign rsp_chan.contacts   = rsp_cont_ff;
   assign rsp_chan.heuristic  = rsp_heur_ff;
   assign rsp_chan.overflow   = rsp_ovf_ff;

   // Assertions
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BEADS))
      else $error("bead count beyond store depth");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (issue_ff <= count_ff))
      else $error("scan read index passed bead count");

   a_done_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> (!rd_vld_ff && (issue_ff == count_ff)))
      else $error("scan finished with reads outstanding");

   a_coll_heur: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_coll_ff != '0)) |-> (rsp_heur_ff == '0))
      else $error("nonzero heuristic reported with a collision");

endmodule

// File: tb/lch_score_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lch_score_checker
// Watches the request and response channels of the lattice contact
// heuristic, keeps its own bead chain, scores each accepted query and
// compares every accepted response against the oldest pending score.
// ----------------------------------------------------------------------------
module lch_score_checker (
   input  logic        clock,
   input  logic        reset,
   lch_req_if          req_chan,
   lch_rsp_if          rsp_chan,
   output int unsigned mismatches,
   output int unsigned queries_open
);

   typedef logic signed [lch_pkg::COORD_BITS-1:0] coord_type;
   typedef logic [lch_pkg::CNT_OUT_W-1:0]         count_type;

   typedef struct packed {
      count_type collisions;
      count_type contacts;
      count_type heuristic;
      logic      overflow;
   } score_type;

   // Chain as the block should hold it.
   coord_type   placed_x [lch_pkg::MAX_BEADS];
   coord_type   placed_y [lch_pkg::MAX_BEADS];
   coord_type   placed_z [lch_pkg::MAX_BEADS];
   bit          placed_h [lch_pkg::MAX_BEADS];
   int unsigned chain_len;
   bit          lost_append;

   score_type   score_q [$];
   int unsigned fails;

   function automatic count_type clip(int unsigned v);
      return (v > lch_pkg::OUT_MAX) ? count_type'(lch_pkg::OUT_MAX) : count_type'(v);
   endfunction

   function automatic int unsigned span(int a, int b);
      return (a >= b) ? a - b : b - a;
   endfunction

   // Walk the whole chain against one candidate site.
   function automatic score_type score_candidate(coord_type cx, coord_type cy,
                                                 coord_type cz, logic h);
      int unsigned hits, touches, l1_dist, heur;
      score_type   score;
      hits    = 0;
      touches = 0;
      for (int j = 0; j < chain_len; j++) begin
         l1_dist = span(cx, placed_x[j]) + span(cy, placed_y[j]) + span(cz, placed_z[j]);
         if (l1_dist == 0) begin
            hits++;
         end else if (l1_dist == 1 && placed_h[j]) begin
            touches++;
         end
      end
      if (hits != 0) begin
         heur = 0;
      end else if (h) begin
         heur = 1 + touches;
      end else begin
         heur = 1;
      end
      score.collisions = clip(hits);
      score.contacts   = clip(touches);
      score.heuristic  = clip(heur);
      score.overflow   = lost_append;
      return score;
   endfunction

   task automatic check_field(string name, count_type want, count_type got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      score_type want;
      if (reset) begin
         chain_len   = 0;
         lost_append = 0;
         fails       = 0;
         score_q.delete();
      end else begin
         // A response always belongs to an earlier query, so check it first.
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            if (score_q.size() == 0) begin
               $error("response with no query outstanding");
               fails++;
            end else begin
               want = score_q.pop_front();
               check_field("collisions", want.collisions, rsp_chan.collisions);
               check_field("contacts", want.contacts, rsp_chan.contacts);
               check_field("heuristic", want.heuristic, rsp_chan.heuristic);
               check_field("overflow", count_type'(want.overflow),
                           {{(lch_pkg::CNT_OUT_W-1){1'b0}}, rsp_chan.overflow});
            end
         end
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) begin
            case (req_chan.operation)
               lch_pkg::OP_CLEAR: begin
                  chain_len   = 0;
                  lost_append = 0;
               end
               lch_pkg::OP_APPEND: begin
                  if (chain_len >= lch_pkg::MAX_BEADS) begin
                     lost_append = 1;
                  end else begin
                     placed_x[chain_len] = req_chan.pos_x;
                     placed_y[chain_len] = req_chan.pos_y;
                     placed_z[chain_len] = req_chan.pos_z;
                     placed_h[chain_len] = req_chan.is_h;
                     chain_len++;
                  end
               end
               lch_pkg::OP_QUERY: begin
                  score_q.push_back(score_candidate(req_chan.pos_x, req_chan.pos_y,
                                                    req_chan.pos_z, req_chan.is_h));
               end
               default: begin
                  // unused code: no effect
               end
            endcase
         end
      end
      mismatches   <= fails;
      queries_open <= score_q.size();
   end

endmodule

// File: tb/tb_lattice_contact_heuristic.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lattice_contact_heuristic
// Drives clear, append and query requests into the lattice contact heuristic
// with random idle gaps and response stalls; a separate checker scores each
// query and the top reports the verdict once all responses are in.
// ----------------------------------------------------------------------------
module tb_lattice_contact_heuristic;

   // The fourth operation code has no name in the package; the block ignores it.
   localparam logic [lch_pkg::OP_W-1:0] OP_IGNORED = 2'd3;

   // Start no new phase once this many real requests (not ignored codes) went in.
   localparam int unsigned REQUEST_BUDGET = 500;
   // Random phase that tries to overfill the store to hit the dropped append.
   localparam int          FILL_PHASE     = 2;
   // Time to let pass at the end, enough for a scan of a full store.
   localparam int unsigned DRAIN_CYCLES   = lch_pkg::MAX_BEADS + 40;
   // Cycles without any handshake before the run is declared hung.
   localparam int unsigned STALL_LIMIT    = 5000;

   typedef struct {
      int x;
      int y;
      int z;
   } site_type;

   logic clock = 1'b0;
   logic reset;

   lch_req_if req_chan ();
   lch_rsp_if rsp_chan ();

   int unsigned mismatches;
   int unsigned queries_open;

   // Sites handed to the block, only used to aim queries near the chain.
   site_type    sites [$];
   int          tip_x, tip_y, tip_z;
   bit          quiet;
   int unsigned requests_sent;
   int unsigned stuck_cycles = 0;

   lattice_contact_heuristic dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   lch_score_checker score_check (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .mismatches   (mismatches),
      .queries_open (queries_open)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Kill the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int unsigned idle_len(bit calm);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic int clamp_coord(int v);
      if (v > 511) begin
         return 511;
      end else if (v < -512) begin
         return -512;
      end
      return v;
   endfunction

   function automatic int random_coord();
      return int'($urandom_range(0, 1023)) - 512;
   endfunction

   function automatic logic random_type();
      return 1'($urandom_range(0, 1));
   endfunction

   // Move one unit along a random axis, clamped to the lattice.
   function automatic void nudge(inout int x, inout int y, inout int z);
      int step;
      step = $urandom_range(0, 1) ? 1 : -1;
      case ($urandom_range(0, 2))
         0:       x = clamp_coord(x + step);
         1:       y = clamp_coord(y + step);
         default: z = clamp_coord(z + step);
      endcase
   endfunction

   // Present one request at a falling edge and hold it until accepted.
   task automatic issue(logic [lch_pkg::OP_W-1:0] op, int x, int y, int z, logic h);
      int unsigned idle;
      idle = idle_len(quiet);
      if (idle != 0) begin
         req_chan.valid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.pos_x     <= x[lch_pkg::COORD_BITS-1:0];
      req_chan.pos_y     <= y[lch_pkg::COORD_BITS-1:0];
      req_chan.pos_z     <= z[lch_pkg::COORD_BITS-1:0];
      req_chan.is_h      <= h;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      @(negedge clock);
      if (op != OP_IGNORED) begin
         requests_sent++;
      end
   endtask

   task automatic place(int x, int y, int z, logic h);
      issue(lch_pkg::OP_APPEND, x, y, z, h);
      if (sites.size() < lch_pkg::MAX_BEADS) begin
         sites.push_back('{x, y, z});
      end
   endtask

   // Random junk on the position fields; a clear ignores them.
   task automatic clear_chain();
      issue(lch_pkg::OP_CLEAR, random_coord(), random_coord(), random_coord(),
            random_type());
      sites.delete();
   endtask

   // Extend the chain by a unit step, with an occasional jump anywhere.
   task automatic grow_step();
      if ($urandom_range(0, 9) == 0) begin
         tip_x = random_coord();
         tip_y = random_coord();
         tip_z = random_coord();
      end else begin
         nudge(tip_x, tip_y, tip_z);
      end
      place(tip_x, tip_y, tip_z, random_type());
   endtask

   // Aim a query at a stored site: on it, one step off, two steps off,
   // or nowhere in particular.
   task automatic probe();
      site_type    s;
      int unsigned kind;
      int          cx, cy, cz;
      kind = $urandom_range(0, 99);
      if (sites.size() == 0 || kind >= 90) begin
         cx = random_coord();
         cy = random_coord();
         cz = random_coord();
      end else begin
         s  = sites[$urandom_range(0, sites.size() - 1)];
         cx = s.x;
         cy = s.y;
         cz = s.z;
         if (kind >= 25) begin
            nudge(cx, cy, cz);
         end
         if (kind >= 65) begin
            nudge(cx, cy, cz);
         end
      end
      issue(lch_pkg::OP_QUERY, cx, cy, cz, random_type());
   endtask

   // Response side: stall in random bursts, with some long clean stretches.
   initial begin
      int unsigned idle;
      int unsigned run;
      rsp_chan.ready = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         idle = ($urandom_range(0, 9) == 0) ? 0 : idle_len(1'b0);
         if (idle != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (idle) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 100) : $urandom_range(1, 6);
         repeat (run) @(negedge clock);
      end
   end

   initial begin
      int          phase;
      int unsigned beads_wanted;
      int unsigned roll;

      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.operation = lch_pkg::OP_CLEAR;
      req_chan.pos_x     = '0;
      req_chan.pos_y     = '0;
      req_chan.pos_z     = '0;
      req_chan.is_h      = 1'b0;
      quiet              = 1'b0;
      requests_sent      = 0;
      tip_x              = 0;
      tip_y              = 0;
      tip_z              = 0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // Query an empty store: no collision, heuristic 1.
      issue(lch_pkg::OP_QUERY, 0, 0, 0, 1'b1);
      place(0, 0, 0, 1'b1);
      place(2, 0, 0, 1'b0);
      place(0, 1, 1, 1'b1);
      // One H neighbor; the P neighbor must not count.
      issue(lch_pkg::OP_QUERY, 1, 0, 0, 1'b1);
      // Same site for a P bead: contacts reported, heuristic stays 1.
      issue(lch_pkg::OP_QUERY, 1, 0, 0, 1'b0);
      // Land on a stored bead: heuristic drops to zero.
      issue(lch_pkg::OP_QUERY, 0, 0, 0, 1'b1);
      // Stack a second bead on the same site for a double collision.
      place(0, 0, 0, 1'b0);
      issue(lch_pkg::OP_QUERY, 0, 0, 0, 1'b0);
      // Unused operation code: must leave the chain alone.
      issue(OP_IGNORED, 0, 1, 0, 1'b1);
      // Two H neighbors on different axes.
      issue(lch_pkg::OP_QUERY, 0, 1, 0, 1'b1);
      // Corners of the lattice.
      place(-512, -512, -512, 1'b1);
      place(511, 511, 511, 1'b1);
      issue(lch_pkg::OP_QUERY, -511, -512, -512, 1'b1);
      issue(lch_pkg::OP_QUERY, 511, 511, 510, 1'b1);
      // Opposite edges are far apart, not neighbors through a wrap.
      issue(lch_pkg::OP_QUERY, -512, 511, 511, 1'b1);
      issue(lch_pkg::OP_QUERY, 511, -512, 511, 1'b0);
      // After a clear the same corner is empty again.
      clear_chain();
      issue(lch_pkg::OP_QUERY, 511, 511, 511, 1'b1);

      // ---- random part ----
      // Each phase grows a chain by a random walk and probes around it;
      // one phase tries to overfill the store.
      phase = 0;
      while (requests_sent < REQUEST_BUDGET) begin
         quiet = ($urandom_range(0, 4) == 0);
         if (phase == FILL_PHASE || $urandom_range(0, 4) != 0) begin
            clear_chain();
         end
         if (phase == FILL_PHASE) begin
            beads_wanted = lch_pkg::MAX_BEADS + $urandom_range(2, 5);
         end else begin
            beads_wanted = $urandom_range(1, 40);
         end
         // Start near the origin mostly, sometimes anywhere (edges included).
         if ($urandom_range(0, 9) < 7) begin
            tip_x = $urandom_range(0, 16) - 8;
            tip_y = $urandom_range(0, 16) - 8;
            tip_z = $urandom_range(0, 16) - 8;
         end else begin
            tip_x = random_coord();
            tip_y = random_coord();
            tip_z = random_coord();
         end
         repeat (beads_wanted) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
               issue(OP_IGNORED, random_coord(), random_coord(), random_coord(),
                     random_type());
            end else if (roll < 5 && phase != FILL_PHASE) begin
               clear_chain();
            end else begin
               grow_step();
            end
            if ($urandom_range(0, 99) < ((phase == FILL_PHASE) ? 8 : 40)) begin
               probe();
            end
         end
         repeat ($urandom_range(1, 4)) probe();
         phase++;
      end
      req_chan.valid <= 1'b0;

      // Drain: wait for every scored query, then give stray responses a chance.
      while (queries_open != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/lch_pkg.sv
rtl/core/lch_if.sv
rtl/core/lch_ram.sv
rtl/core/lattice_contact_heuristic.sv
tb/lch_score_checker.sv
tb/tb_lattice_contact_heuristic.sv
